### rtl/core/gbc_pkg.sv
// Shared types and constants for the gyro bias calibrate/correct block.
// No dependencies; every other file in rtl/core imports this package.
package gbc_pkg;

  localparam int unsigned AXES   = 3;
  localparam int unsigned DATA_W = 16;
  localparam int unsigned CNT_W  = 16;

  localparam logic [CNT_W-1:0]         CAL_SAMPLES_RST = 16'd1000;
  localparam logic signed [DATA_W-1:0] MIN_START       = 16'sh7FFF;  // +32767
  localparam logic signed [DATA_W-1:0] MAX_START       = 16'sh8001;  // -32767
  localparam logic signed [DATA_W-1:0] S16_MAX         = 16'sh7FFF;
  localparam logic signed [DATA_W-1:0] S16_MIN         = 16'sh8000;

  typedef enum logic {
    ACT_MEASURE   = 1'b0,
    ACT_CALIBRATE = 1'b1
  } action_e;

  typedef enum logic {
    KIND_MEASURE  = 1'b0,
    KIND_CAL_DONE = 1'b1
  } kind_e;

  // Per-lane update strobe and end-of-run flag
  typedef struct packed {
    logic upd;
    logic done;
  } lane_ctrl_t;

  // What one axis lane reports for the current sample
  typedef struct packed {
    logic signed [DATA_W-1:0] mid;
    logic signed [DATA_W-1:0] corr;
    logic                     clip;
  } lane_res_t;

  typedef struct packed {
    kind_e                       kind;
    logic [AXES-1:0][DATA_W-1:0] value;
    logic                        sat;
  } result_t;

endpackage

### rtl/core/gbc_lane.sv
// One axis lane: running min/max, offset register, midpoint and corrected rate.
// Depends on gbc_pkg.
module gbc_lane (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  gbc_pkg::lane_ctrl_t              ctrl_i,
  input  logic signed [gbc_pkg::DATA_W-1:0] raw_i,
  output gbc_pkg::lane_res_t               res_o
);
  import gbc_pkg::*;

  logic signed [DATA_W-1:0] min_q, min_d, max_q, max_d, off_q, off_d;
  logic signed [DATA_W-1:0] min_new, max_new;
  logic signed [DATA_W:0]   sum, sum_adj, diff;

  always_comb begin
    max_new = (raw_i > max_q) ? raw_i : max_q;
    min_new = (raw_i < min_q) ? raw_i : min_q;
    // halve toward zero: add one before the shift when negative
    sum     = {max_new[DATA_W-1], max_new} + {min_new[DATA_W-1], min_new};
    sum_adj = sum + {{DATA_W{1'b0}}, sum[DATA_W]};
    diff    = {raw_i[DATA_W-1], raw_i} - {off_q[DATA_W-1], off_q};

    res_o.mid  = DATA_W'(sum_adj >>> 1);
    res_o.clip = diff[DATA_W] ^ diff[DATA_W-1];
    if (res_o.clip) begin
      res_o.corr = diff[DATA_W] ? S16_MIN : S16_MAX;
    end else begin
      res_o.corr = diff[DATA_W-1:0];
    end

    min_d = min_q;
    max_d = max_q;
    off_d = off_q;
    if (ctrl_i.upd) begin
      if (ctrl_i.done) begin
        min_d = MIN_START;
        max_d = MAX_START;
        off_d = res_o.mid;
      end else begin
        min_d = min_new;
        max_d = max_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= MIN_START;
      max_q <= MAX_START;
      off_q <= '0;
    end else begin
      min_q <= min_d;
      max_q <= max_d;
      off_q <= off_d;
    end
  end

endmodule

### rtl/core/gbc_merge.sv
// Merge stage: sample counter, run-length register, combining of lane outputs.
// Depends on gbc_pkg.
module gbc_merge (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       accept_i,
  input  logic                                       action_i,
  input  logic                                       cfg_we_i,
  input  logic [gbc_pkg::CNT_W-1:0]                  cfg_data_i,
  input  gbc_pkg::lane_res_t [gbc_pkg::AXES-1:0]     lane_res_i,
  output gbc_pkg::lane_ctrl_t                        lane_ctrl_o,
  output logic                                       push_o,
  output gbc_pkg::result_t                           result_o
);
  import gbc_pkg::*;

  logic [CNT_W-1:0] cal_samples_q, cal_samples_d;
  logic [CNT_W-1:0] cnt_q, cnt_d, cnt_next;
  logic             is_cal, run_done;

  always_comb begin
    is_cal   = (action_i == ACT_CALIBRATE);
    cnt_next = cnt_q + CNT_W'(1);
    run_done = (cnt_next >= cal_samples_q);

    lane_ctrl_o.upd  = accept_i && is_cal;
    lane_ctrl_o.done = run_done;

    cnt_d = cnt_q;
    if (lane_ctrl_o.upd) begin
      cnt_d = run_done ? '0 : cnt_next;
    end
    cal_samples_d = cfg_we_i ? cfg_data_i : cal_samples_q;

    push_o = accept_i && (!is_cal || run_done);

    result_o.kind = is_cal ? KIND_CAL_DONE : KIND_MEASURE;
    result_o.sat  = 1'b0;
    for (int a = 0; a < AXES; a++) begin
      result_o.value[a] = is_cal ? lane_res_i[a].mid : lane_res_i[a].corr;
      if (!is_cal && lane_res_i[a].clip) begin
        result_o.sat = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_samples_q <= CAL_SAMPLES_RST;
      cnt_q         <= '0;
    end else begin
      cal_samples_q <= cal_samples_d;
      cnt_q         <= cnt_d;
    end
  end

endmodule

### rtl/core/gbc_skid.sv
// Two-entry output buffer that decouples result delivery from input acceptance.
// Depends on gbc_pkg.
module gbc_skid (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  gbc_pkg::result_t  data_i,
  output logic              ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output gbc_pkg::result_t  data_o
);
  import gbc_pkg::*;

  result_t head_q, head_d, spare_q, spare_d;
  logic    head_vld_q, head_vld_d, spare_vld_q, spare_vld_d;
  logic    pop;

  assign ready_o     = !spare_vld_q;
  assign out_valid_o = head_vld_q;
  assign data_o      = head_q;

  always_comb begin
    pop         = head_vld_q && out_ready_i;
    head_d      = head_q;
    head_vld_d  = head_vld_q;
    spare_d     = spare_q;
    spare_vld_d = spare_vld_q;
    if (pop) begin
      // advance the spare entry into the head
      head_d      = spare_q;
      head_vld_d  = spare_vld_q;
      spare_vld_d = 1'b0;
    end
    if (push_i) begin
      if (!head_vld_d) begin
        head_d     = data_i;
        head_vld_d = 1'b1;
      end else begin
        spare_d     = data_i;
        spare_vld_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_vld_q  <= 1'b0;
      spare_vld_q <= 1'b0;
    end else begin
      head_vld_q  <= head_vld_d;
      spare_vld_q <= spare_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q  <= head_d;
    spare_q <= spare_d;
  end

endmodule

### rtl/core/gyro_bias_calibrate_correct.sv
// Top level of the gyro bias calibrate/correct block.
// Depends on gbc_pkg, gbc_lane, gbc_merge and gbc_skid.
//
// Gyro bias calibration and correction. Each input transaction carries one
// three-axis raw sample tagged by action_i: a calibration sample updates the
// per-axis running minimum and maximum, and once calibration_samples of them
// have been gathered (a value of zero acts as one) the offsets become the
// min/max midpoint, truncated toward zero, and one result with
// result_kind_o = 1 reports them; the run then restarts. A measurement sample
// has the offsets subtracted, clipped to 16 bits (saturated_o flags any
// clipped axis), and comes out as a Q11.4 rate in deg/s, since the sensor
// gives 16 counts per deg/s. Calibration samples that do not close a run give
// no result. The block takes one transaction per clock: three axis lanes work
// side by side in the accept cycle and a merge stage forms the result, which
// is registered in the output buffer. A two-entry output buffer lets input
// keep flowing while a result waits; in_ready_o drops only when both entries
// are held. The run length is written through the cfg channel, which is
// always ready; write it only while the block is idle.
module gyro_bias_calibrate_correct (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // sample channel
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              action_i,
  input  logic signed [gbc_pkg::DATA_W-1:0] raw_x_i,
  input  logic signed [gbc_pkg::DATA_W-1:0] raw_y_i,
  input  logic signed [gbc_pkg::DATA_W-1:0] raw_z_i,
  // result channel
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              result_kind_o,
  output logic signed [gbc_pkg::DATA_W-1:0] value_x_o,
  output logic signed [gbc_pkg::DATA_W-1:0] value_y_o,
  output logic signed [gbc_pkg::DATA_W-1:0] value_z_o,
  output logic                              saturated_o,
  // run-length register write
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [gbc_pkg::CNT_W-1:0]         cfg_data_i
);
  import gbc_pkg::*;

  logic                                 accept;
  logic signed [AXES-1:0][DATA_W-1:0]   raw;
  lane_ctrl_t                           lane_ctrl;
  lane_res_t [AXES-1:0]                 lane_res;
  logic                                 push;
  result_t                              result, out_data;

  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && in_ready_o;
  assign raw         = {raw_z_i, raw_y_i, raw_x_i};

  // one lane per axis, all fed from the same transaction
  for (genvar a = 0; a < AXES; a++) begin : g_lane
    gbc_lane u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (lane_ctrl),
      .raw_i  (raw[a]),
      .res_o  (lane_res[a])
    );
  end

  gbc_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .action_i    (action_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .lane_res_i  (lane_res),
    .lane_ctrl_o (lane_ctrl),
    .push_o      (push),
    .result_o    (result)
  );

  gbc_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .data_i      (result),
    .ready_o     (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .data_o      (out_data)
  );

  assign result_kind_o = out_data.kind;
  assign value_x_o     = $signed(out_data.value[0]);
  assign value_y_o     = $signed(out_data.value[1]);
  assign value_z_o     = $signed(out_data.value[2]);
  assign saturated_o   = out_data.sat;

endmodule

### rtl/core/gbc_checker.sv
// Port-level checker for gyro_bias_calibrate_correct, attached by bind.
// Depends on gbc_pkg.
module gbc_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_ready_o,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic                              result_kind_o,
  input logic signed [gbc_pkg::DATA_W-1:0] value_x_o,
  input logic signed [gbc_pkg::DATA_W-1:0] value_y_o,
  input logic signed [gbc_pkg::DATA_W-1:0] value_z_o,
  input logic                              saturated_o
);
  import gbc_pkg::*;

  // Hold a stalled result's values and saturated flag unchanged
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(value_x_o)
      && $stable(value_y_o) && $stable(value_z_o) && $stable(saturated_o))
    else $error("stalled result changed");

  // Drop ready only while a result is pending
  a_ready_buf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with empty output");

  // Offsets report never carries a clip flag
  a_cal_nosat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o == KIND_CAL_DONE |-> !saturated_o)
    else $error("saturated set on calibration result");

  // A clipped measurement shows a rail value on some axis
  a_sat_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o == KIND_MEASURE && saturated_o |->
      value_x_o == S16_MAX || value_x_o == S16_MIN ||
      value_y_o == S16_MAX || value_y_o == S16_MIN ||
      value_z_o == S16_MAX || value_z_o == S16_MIN)
    else $error("saturated without a rail value");

endmodule

bind gyro_bias_calibrate_correct gbc_checker u_gbc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .result_kind_o (result_kind_o),
  .value_x_o     (value_x_o),
  .value_y_o     (value_y_o),
  .value_z_o     (value_z_o),
  .saturated_o   (saturated_o)
);
